// ===== rtl/monotonic_counter_time_of_day_macros.svh =====
// assertion macros for the monotonic time-of-day reader
`ifndef MONOTONIC_COUNTER_TIME_OF_DAY_MACROS_SVH
`define MONOTONIC_COUNTER_TIME_OF_DAY_MACROS_SVH

// same-cycle implication, sampled on clk, quiet while arst_n is low
`define TOD_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("time-of-day check failed");

// next-cycle implication
`define TOD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("time-of-day check failed");

`endif

// ===== rtl/tod_pkg.sv =====
// shared constants, register codes and stage types of the time-of-day reader
package tod_pkg;

	localparam int TICKS_PER_SECOND = 100;
	localparam int USEC_PER_SEC     = 1000000;
	localparam int USEC_PER_TICK    = USEC_PER_SEC / TICKS_PER_SECOND;
	localparam int LOST_US_W        = 16 + $clog2(USEC_PER_TICK + 1);

	// 1000000 = 2^6 * 15625: the low six bits pass straight into the remainder
	localparam int DIV_SHIFT   = 6;
	localparam int DIV_ODD     = USEC_PER_SEC / (2 ** DIV_SHIFT);
	localparam int RECIP_SHIFT = 44;
	localparam longint unsigned DIV_RECIP_FULL = (64'd1 << RECIP_SHIFT) / DIV_ODD;
	localparam logic [30:0] DIV_RECIP = DIV_RECIP_FULL[30:0];

	localparam int IN_W  = 168;
	localparam int OUT_W = 56;

	typedef enum logic [1:0] {
		REG_COUNTER_SHIFT  = 2'd0,
		REG_SCALE_FRACTION = 2'd1,
		REG_SCALE_INTEGER  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0]  counter_shift;
		logic [31:0] scale_fraction;
		logic [31:0] scale_integer;
	} cfg_t;

	// what rides along with the quotient digits through the divider
	typedef struct packed {
		logic [31:0] base_seconds;
		logic        reset_floor;
		logic [31:0] rest;
	} side_t;

endpackage

// ===== rtl/tod_elapsed.sv =====
// counter difference, scale multiplies and microsecond sum (three stages)
module tod_elapsed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [63:0]        counter_now,
	input  logic [31:0]        counter_stamp,
	input  logic [15:0]        pending_ticks,
	input  logic [31:0]        base_seconds,
	input  logic [19:0]        base_micros,
	input  logic               reset_floor,
	input  tod_pkg::cfg_t      cfg,
	output logic               out_valid,
	output logic [31:0]        total_hi,
	output tod_pkg::side_t     side_out
);
	import tod_pkg::*;

	logic [63:0] shifted_c;
	logic [31:0] diff_c;

	logic                 v_s1, v_s2, v_s3;
	logic [30:0]          d_s1;
	logic [15:0]          lost_s1;
	logic [19:0]          micros_s1, micros_s2;
	logic [31:0]          sec_s1, sec_s2, sec_s3;
	logic                 rf_s1, rf_s2, rf_s3;
	logic [62:0]          prod_f_c, prod_i_c;
	logic [62:0]          prod_f_s2, prod_i_s2;
	logic [LOST_US_W-1:0] lost_us_s2;
	logic [63:0]          total_s3;

	assign shifted_c = counter_now >> cfg.counter_shift;
	assign diff_c    = shifted_c[31:0] - counter_stamp;
	assign prod_f_c  = d_s1 * cfg.scale_fraction;
	assign prod_i_c  = d_s1 * cfg.scale_integer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// counter behind the stamp counts as no time elapsed
			d_s1       <= diff_c[31] ? 31'd0 : diff_c[30:0];
			lost_s1    <= pending_ticks;
			micros_s1  <= base_micros;
			sec_s1     <= base_seconds;
			rf_s1      <= reset_floor;

			prod_f_s2  <= prod_f_c;
			prod_i_s2  <= prod_i_c;
			lost_us_s2 <= LOST_US_W'(lost_s1) * LOST_US_W'(USEC_PER_TICK);
			micros_s2  <= micros_s1;
			sec_s2     <= sec_s1;
			rf_s2      <= rf_s1;

			total_s3   <= 64'(prod_f_s2[62:32]) + 64'(prod_i_s2)
			            + 64'(lost_us_s2) + 64'(micros_s2);
			sec_s3     <= sec_s2;
			rf_s3      <= rf_s2;
		end
	end

	assign out_valid             = v_s3;
	assign total_hi              = total_s3[63:32];
	assign side_out.base_seconds = sec_s3;
	assign side_out.reset_floor  = rf_s3;
	assign side_out.rest         = total_s3[31:0];

endmodule

// ===== rtl/tod_div_step.sv =====
// one quotient digit of the divide by one million: reciprocal multiply, then correction
module tod_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [35:0]    x,
	input  logic [31:0]    q_in,
	input  tod_pkg::side_t side_in,
	output logic           out_valid,
	output logic [19:0]    r_out,
	output logic [31:0]    q_out,
	output tod_pkg::side_t side_out
);
	import tod_pkg::*;

	logic [29:0] xh_c;
	logic [60:0] prod_c;

	logic        v_s1, v_s2;
	logic [29:0] xh_s1;
	logic [5:0]  xl_s1;
	logic [15:0] qe_s1;
	logic [31:0] q_in_s1;
	side_t       side_s1;

	logic [29:0] rr_c;
	logic        fix_c;
	logic [29:0] rem_c;

	logic [19:0] r_s2;
	logic [31:0] q_s2;
	side_t       side_s2;

	assign xh_c   = x[35:DIV_SHIFT];
	assign prod_c = xh_c * DIV_RECIP;

	// estimate is the true quotient or one below it
	assign rr_c  = xh_s1 - 30'(qe_s1 * 30'(DIV_ODD));
	assign fix_c = rr_c >= 30'(DIV_ODD);
	assign rem_c = fix_c ? rr_c - 30'(DIV_ODD) : rr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xh_s1   <= xh_c;
			xl_s1   <= x[DIV_SHIFT-1:0];
			qe_s1   <= prod_c[RECIP_SHIFT +: 16];
			q_in_s1 <= q_in;
			side_s1 <= side_in;

			r_s2    <= {rem_c[13:0], xl_s1};
			q_s2    <= {q_in_s1[15:0], qe_s1 + 16'(fix_c)};
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign r_out     = r_s2;
	assign q_out     = q_s2;
	assign side_out  = side_s2;

endmodule

// ===== rtl/tod_out.sv =====
// seconds add, monotonic floor clamp and output register with skid stage
module tod_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [31:0]    quot,
	input  logic [19:0]    micros,
	input  tod_pkg::side_t side,
	output logic           ready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [31:0]    time_seconds,
	output logic [19:0]    time_micros
);
	import tod_pkg::*;

	logic [31:0] floor_sec_q;
	logic [19:0] floor_us_q;
	logic        out_valid_q, skid_valid_q;
	logic [31:0] out_sec_q, skid_sec_q;
	logic [19:0] out_us_q, skid_us_q;

	logic [31:0] sec_c, floor_sec_c, res_sec_c;
	logic [19:0] res_us_c;
	logic        below_c, load_c, direct_c;

	assign ready = !skid_valid_q;

	assign sec_c       = side.base_seconds + quot;
	// a floor reset clears only the seconds; the microseconds still compare
	assign floor_sec_c = side.reset_floor ? 32'd0 : floor_sec_q;
	assign below_c     = (sec_c < floor_sec_c)
	                   || ((sec_c == floor_sec_c) && (micros < floor_us_q));
	assign res_sec_c   = below_c ? floor_sec_c : sec_c;
	assign res_us_c    = below_c ? floor_us_q : micros;

	assign load_c   = ready && in_valid;
	assign direct_c = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_sec_q  <= 32'd0;
			floor_us_q   <= 20'd0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (load_c) begin
				floor_sec_q <= res_sec_c;
				floor_us_q  <= res_us_c;
			end
			if (load_c && direct_c) begin
				out_valid_q <= 1'b1;
			end else if (load_c) begin
				skid_valid_q <= 1'b1;
			end else if (m_tready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_c && direct_c) begin
			out_sec_q <= res_sec_c;
			out_us_q  <= res_us_c;
		end else if (load_c) begin
			skid_sec_q <= res_sec_c;
			skid_us_q  <= res_us_c;
		end else if (m_tready && skid_valid_q) begin
			out_sec_q <= skid_sec_q;
			out_us_q  <= skid_us_q;
		end
	end

	assign m_tvalid     = out_valid_q;
	assign time_seconds = out_sec_q;
	assign time_micros  = out_us_q;

endmodule

// ===== rtl/monotonic_counter_time_of_day.sv =====
// Monotonic time-of-day reader. Each input transaction carries a raw cycle counter, the
// shifted counter stamp and base wall time of the current time base, and the ticks not
// yet folded in; the block returns one transaction with whole seconds and microseconds
// that never fall below the previous result unless reset_floor is set. Fully pipelined: one
// transaction is taken every cycle while s_tready is high, and its result passes through ten
// register stages on its way to m_tdata: three for the difference, the two 32-bit scale
// multiplies and the sum, six for the divide by one million done as three
// reciprocal-multiply digit steps, and the output register where the floor clamp sits.
// s_tready drops only while the skid stage holds a result that the sink has not taken.
// Configuration writes are always accepted and should be made while the block is idle.
// No clearing pass after reset.
module monotonic_counter_time_of_day (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// counter_now, counter_stamp, pending_ticks, base_seconds, base_micros, reset_floor
	input  logic [tod_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// time_seconds, time_micros
	output logic [tod_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [31:0]                cfg_data
);
	import tod_pkg::*;

	cfg_t        cfg_q;
	logic        en;

	logic        e_valid;
	logic [31:0] e_total_hi;
	side_t       e_side;

	logic        a_valid, b_valid, c_valid;
	logic [19:0] a_r, b_r, c_r;
	logic [31:0] a_q, b_q, c_q;
	side_t       a_side, b_side, c_side;

	logic [31:0] time_seconds;
	logic [19:0] time_micros;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COUNTER_SHIFT:  cfg_q.counter_shift  <= cfg_data[4:0];
				REG_SCALE_FRACTION: cfg_q.scale_fraction <= cfg_data;
				REG_SCALE_INTEGER:  cfg_q.scale_integer  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = en;

	tod_elapsed u_elapsed (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (s_tvalid),
		.counter_now   (s_tdata[63:0]),
		.counter_stamp (s_tdata[95:64]),
		.pending_ticks (s_tdata[111:96]),
		.base_seconds  (s_tdata[143:112]),
		.base_micros   (s_tdata[163:144]),
		.reset_floor   (s_tdata[164]),
		.cfg           (cfg_q),
		.out_valid     (e_valid),
		.total_hi      (e_total_hi),
		.side_out      (e_side)
	);

	// upper word first; its quotient only matters above bit 31 and shifts out
	tod_div_step u_div_a (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (e_valid),
		.x         ({4'd0, e_total_hi}),
		.q_in      (32'd0),
		.side_in   (e_side),
		.out_valid (a_valid),
		.r_out     (a_r),
		.q_out     (a_q),
		.side_out  (a_side)
	);

	tod_div_step u_div_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (a_valid),
		.x         ({a_r, a_side.rest[31:16]}),
		.q_in      (a_q),
		.side_in   (a_side),
		.out_valid (b_valid),
		.r_out     (b_r),
		.q_out     (b_q),
		.side_out  (b_side)
	);

	tod_div_step u_div_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (b_valid),
		.x         ({b_r, b_side.rest[15:0]}),
		.q_in      (b_q),
		.side_in   (b_side),
		.out_valid (c_valid),
		.r_out     (c_r),
		.q_out     (c_q),
		.side_out  (c_side)
	);

	tod_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (c_valid),
		.quot         (c_q),
		.micros       (c_r),
		.side         (c_side),
		.ready        (en),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.time_seconds (time_seconds),
		.time_micros  (time_micros)
	);

	assign m_tdata = {4'd0, time_micros, time_seconds};

endmodule

// ===== rtl/tod_checker.sv =====
// port-level checks of the time-of-day reader and their binding
`include "monotonic_counter_time_of_day_macros.svh"

module tod_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tod_pkg::OUT_W-1:0] m_tdata
);
	import tod_pkg::*;

	// microseconds always normalised below one second
	`TOD_ASSERT(a_micros_range, m_tvalid, m_tdata[51:32] < 20'(USEC_PER_SEC))
	`TOD_ASSERT(a_pad_zero, m_tvalid, m_tdata[55:52] == 4'd0)
	// input stalls only with a full skid stage behind a held result
	`TOD_ASSERT(a_stall_needs_out, !s_tready, m_tvalid)
	`TOD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind monotonic_counter_time_of_day tod_checker u_tod_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
